>>> rtl/mlp_forward_inference_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MLP forward inference unit
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MLP_FORWARD_INFERENCE_UNIT_DEFINES_SVH
`define MLP_FORWARD_INFERENCE_UNIT_DEFINES_SVH

// same-cycle implication
`define MFI_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mfi assertion failed");

// next-cycle implication
`define MFI_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mfi assertion failed");

`endif

>>> rtl/mfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLP forward inference package
// Shared constants, codes, pipeline tag type and the sigmoid table builder.
// ----------------------------------------------------------------------------
package mfi_pkg;

   localparam int MAX_INPUTS_DEF   = 1024;
   localparam int MAX_HIDDEN_DEF   = 256;
   localparam int WEIGHT_WORDS_DEF = 524288;

   localparam int SIG_ENTRIES = 256;
   localparam int BIAS_WORDS  = 1024;
   localparam int BIAS_AW     = 10;

   localparam int FEAT_W = 16;
   localparam int WGT_W  = 16;
   localparam int BIAS_W = 32;
   localparam int PROD_W = 33;
   localparam int SUM_W  = 48;
   localparam int ACT_W  = 11;
   localparam int PROB_W = 16;

   localparam longint SIG_SPAN = 64'sd8388608;
   localparam longint unsigned Q30 = 64'd1073741824;

   typedef enum logic [1:0] {
      OP_WRITE_WEIGHT = 2'd0,
      OP_WRITE_BIAS   = 2'd1,
      OP_FEATURE      = 2'd2,
      OP_NONE         = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_LAYER_COUNT = 3'd0,
      CSR_INPUT_WIDTH = 3'd1,
      CSR_HIDDEN_ONE  = 3'd2,
      CSR_HIDDEN_TWO  = 3'd3,
      CSR_DUPLICATE   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      SRC_FEATURE    = 2'd0,
      SRC_HIDDEN_ONE = 2'd1,
      SRC_HIDDEN_TWO = 2'd2
   } src_kind_type;

   // tag that travels with each memory read issued to the MAC pipeline
   typedef struct packed {
      logic         valid;
      logic         first;
      logic         last;
      src_kind_type kind;
      logic         wzero;
      logic         bzero;
   } mfi_issue_type;

   typedef logic [PROB_W-1:0] sig_table_type [SIG_ENTRIES+1];

   // restoring shift-subtract quotient, used only while building the table
   function automatic longint unsigned udiv_u64(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned rem;
      q   = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = (rem << 1) | ((n >> b) & 64'd1);
         if (rem >= d) begin
            rem = rem - d;
            q   = q | (64'd1 << b);
         end
      end
      return q;
   endfunction

   // interpolation points of the sigmoid over -8..+8, evaluated at elaboration
   function automatic sig_table_type build_sig_table();
      sig_table_type      tab;
      longint             x;
      longint unsigned    t;
      longint unsigned    y;
      longint unsigned    y2;
      longint unsigned    y3;
      longint unsigned    e;
      longint unsigned    num;
      longint unsigned    den;
      longint unsigned    v;
      for (int i = 0; i <= SIG_ENTRIES; i++) begin
         x  = longint'((longint'(i) <<< 24) / SIG_ENTRIES) - SIG_SPAN;
         t  = (x < 0) ? longint'(-x) : longint'(x);
         y  = t << 2;
         y2 = (y * y) >> 30;
         y3 = (y2 * y) >> 30;
         e  = Q30 - y + (y2 >> 1) - udiv_u64(y3, 64'd6);
         for (int k = 0; k < 8; k++) begin
            e = (e * e + 64'd536870912) >> 30;
         end
         num = (x < 0) ? e : Q30;
         den = Q30 + e;
         v   = udiv_u64((num << 16) + (den >> 1), den);
         tab[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
      return tab;
   endfunction

endpackage

>>> rtl/mfi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mfi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/mfi_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-accumulate pipeline
// Multiplies weight by source, adds into a 48-bit sum seeded with the bias,
// and gives the clipped ReLU of the finished sum.
// ----------------------------------------------------------------------------
module mfi_mac
   import mfi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  mfi_issue_type        issue,
   input  logic [WGT_W-1:0]     weight_rdata,
   input  logic [BIAS_W-1:0]    bias_rdata,
   input  logic [FEAT_W-1:0]    feat_rdata,
   input  logic [ACT_W-1:0]     hone_rdata,
   input  logic [ACT_W-1:0]     htwo_rdata,
   output logic                 done,
   output logic [SUM_W-1:0]     sum,
   output logic [ACT_W-1:0]     act
);

   mfi_issue_type           iss1_ff;
   logic                    v2_ff;
   logic                    first2_ff;
   logic                    last2_ff;
   logic signed [PROD_W-1:0] prod2_ff;
   logic signed [PROD_W-1:0] prod2_in;
   logic signed [BIAS_W-1:0] bias2_ff;
   logic signed [BIAS_W-1:0] bias2_in;
   logic signed [SUM_W-1:0]  acc_ff;
   logic signed [SUM_W-1:0]  acc_in;
   logic                    done_ff;
   logic signed [FEAT_W:0]   src;
   logic signed [WGT_W-1:0]  wgt;

   always_comb begin
      unique case (iss1_ff.kind)
         SRC_FEATURE:    src = {feat_rdata[FEAT_W-1], feat_rdata};
         SRC_HIDDEN_ONE: src = (FEAT_W+1)'(hone_rdata);
         SRC_HIDDEN_TWO: src = (FEAT_W+1)'(htwo_rdata);
         default:        src = '0;
      endcase
      wgt      = iss1_ff.wzero ? '0 : $signed(weight_rdata);
      prod2_in = PROD_W'(wgt * src);
      bias2_in = iss1_ff.bzero ? '0 : $signed(bias_rdata);
      acc_in   = (first2_ff ? SUM_W'(bias2_ff) : acc_ff) + SUM_W'(prod2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss1_ff <= '0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         iss1_ff <= issue;
         v2_ff   <= iss1_ff.valid;
         done_ff <= v2_ff & last2_ff;
      end
      first2_ff <= iss1_ff.first;
      last2_ff  <= iss1_ff.last;
      prod2_ff  <= prod2_in;
      if (iss1_ff.first) begin
         bias2_ff <= bias2_in;
      end
      if (v2_ff) begin
         acc_ff <= acc_in;
      end
   end

   // clipped ReLU to 0..1.0 in Q1.10
   always_comb begin
      priority if (acc_ff <= 0) begin
         act = '0;
      end else if (acc_ff >= 48'sd1048576) begin
         act = 11'd1024;
      end else begin
         act = acc_ff[20:10];
      end
   end

   assign done = done_ff;
   assign sum  = acc_ff;

endmodule

>>> rtl/mfi_sigmoid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Table sigmoid
// Clamps the sum to -8..+8, looks up two table points and interpolates
// linearly; four pipeline stages from start to done.
// ----------------------------------------------------------------------------
module mfi_sigmoid
   import mfi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  sum,
   output logic              done,
   output logic [PROB_W-1:0] prob
);

   localparam int IDX_W = $clog2(SIG_ENTRIES + 1);
   localparam int P_W   = 24 + IDX_W;
   localparam sig_table_type SIG_TABLE = build_sig_table();

   logic [3:0]              vld_ff;
   logic signed [SUM_W-1:0] s_cl;
   logic [23:0]             u;
   logic [P_W-1:0]          p;
   logic [IDX_W-1:0]        idx_ff;
   logic [23:0]             f_ff;
   logic [23:0]             f2_ff;
   logic [PROB_W-1:0]       lo_ff;
   logic [PROB_W-1:0]       hi_ff;
   logic [PROB_W-1:0]       lo3_ff;
   logic                    up3_ff;
   logic [PROB_W-1:0]       diff;
   logic [39:0]             prod3_ff;
   logic [PROB_W-1:0]       prob_ff;
   logic [PROB_W-1:0]       prob_in;

   always_comb begin
      priority if ($signed(sum) < -48'sd8388608) begin
         s_cl = -48'sd8388608;
      end else if ($signed(sum) > 48'sd8388607) begin
         s_cl = 48'sd8388607;
      end else begin
         s_cl = $signed(sum);
      end
      u       = 24'(s_cl + 48'sd8388608);
      p       = P_W'(u) * P_W'(SIG_ENTRIES);
      diff    = (hi_ff >= lo_ff) ? (hi_ff - lo_ff) : (lo_ff - hi_ff);
      prob_in = up3_ff ? (lo3_ff + prod3_ff[39:24]) : (lo3_ff - prod3_ff[39:24]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
      idx_ff   <= p[P_W-1:24];
      f_ff     <= p[23:0];
      lo_ff    <= SIG_TABLE[idx_ff];
      hi_ff    <= SIG_TABLE[idx_ff + IDX_W'(1)];
      f2_ff    <= f_ff;
      up3_ff   <= hi_ff >= lo_ff;
      lo3_ff   <= lo_ff;
      prod3_ff <= 40'(diff) * 40'(f2_ff);
      if (vld_ff[2]) begin
         prob_ff <= prob_in;
      end
   end

   assign done = vld_ff[3];
   assign prob = prob_ff;

endmodule

>>> rtl/mlp_forward_inference_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MLP forward inference unit
// Two to four layer fixed-point network with a clipped ReLU hidden stage and
// a table sigmoid output.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries weight writes, bias writes and features.
//   A weight or bias write or a non-last feature leaves req_ready high. A feature
//   marked last starts a pass; no req transfer is taken until it ends.
//   csr port writes one configuration register per cycle, with no wait.
//   Pass steps: for every neuron, each input column goes through the
//   shared multiply-accumulate unit, whose pipeline then drains; for the
//   output neuron the sigmoid follows, and then the rsp register is loaded.
//   One result per pass goes to the rsp output register. If the receiver
//   stalls, weight and bias writes and features keep being taken; a second
//   pass waits at its end until the earlier result has been transferred.
//   After reset the bias store is cleared, one entry a cycle, all 1024
//   entries; req_ready stays low meanwhile. Configuration returns to 4 layers,
//   768 inputs, 256 and 32 hidden neurons, no duplication.
// ----------------------------------------------------------------------------
module mlp_forward_inference_unit
   import mfi_pkg::*;
#(
   parameter int MAX_INPUTS   = MAX_INPUTS_DEF,
   parameter int MAX_HIDDEN   = MAX_HIDDEN_DEF,
   parameter int WEIGHT_WORDS = WEIGHT_WORDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [18:0]          req_address,
   input  logic signed [15:0]   req_weight_value,
   input  logic signed [31:0]   req_bias_value,
   input  logic signed [15:0]   req_feature_value,
   input  logic                 req_last_feature,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [15:0]          rsp_probability,
   output logic signed [47:0]   rsp_raw_sum,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [10:0]          csr_wdata
);

`include "mlp_forward_inference_unit_defines.svh"

   localparam int FEAT_AW   = $clog2(MAX_INPUTS);
   localparam int HID_AW    = $clog2(MAX_HIDDEN);
   localparam int WADDR_W   = $clog2(WEIGHT_WORDS);
   localparam int IN_CNT_W  = $clog2(MAX_INPUTS + 1);
   localparam int HID_CNT_W = $clog2(MAX_HIDDEN + 1);
   localparam int COL_MAX   = (MAX_INPUTS > 2 * MAX_HIDDEN) ? MAX_INPUTS : 2 * MAX_HIDDEN;
   localparam int COL_W     = $clog2(COL_MAX + 1);
   localparam longint W_BOUND = longint'(MAX_INPUTS) * MAX_HIDDEN
                              + 2 * longint'(MAX_HIDDEN) * MAX_HIDDEN + MAX_HIDDEN + 1;
   localparam int WCNT_A    = $clog2(W_BOUND);
   localparam int WCNT_W    = (WCNT_A > WADDR_W + 1) ? WCNT_A : WADDR_W + 1;
   localparam int BCNT_A    = $clog2(2 * MAX_HIDDEN + 2);
   localparam int BCNT_W    = (BCNT_A > BIAS_AW + 1) ? BCNT_A : BIAS_AW + 1;
   localparam int NIN_RST   = (768 > MAX_INPUTS) ? MAX_INPUTS : 768;
   localparam int H1_RST    = (256 > MAX_HIDDEN) ? MAX_HIDDEN : 256;
   localparam int H2_RST    = (32 > MAX_HIDDEN) ? MAX_HIDDEN : 32;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_MAC   = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_SIG   = 6'b010000,
      ST_HOLD  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [2:0]             nl_ff, nl_in;
   logic [IN_CNT_W-1:0]    nin_ff, nin_in;
   logic [HID_CNT_W-1:0]   h1_ff, h1_in;
   logic [HID_CNT_W-1:0]   h2_ff, h2_in;
   logic                   dup_ff, dup_in;
   logic [IN_CNT_W-1:0]    pos_ff, pos_in;
   logic [1:0]             lyr_ff, lyr_in;
   logic [HID_CNT_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [WCNT_W-1:0]      waddr_ff, waddr_in;
   logic [BCNT_W-1:0]      baddr_ff, baddr_in;
   logic [BIAS_AW-1:0]     clr_ff, clr_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PROB_W-1:0]      rsp_prob_ff;
   logic [SUM_W-1:0]       rsp_raw_ff;

   logic                   req_fire;
   op_type                 op;
   logic                   feat_we;
   logic                   wgt_we;
   logic                   bias_req_we;
   logic                   is_out;
   logic [COL_W-1:0]       cols;
   logic [HID_CNT_W-1:0]   rows;
   logic [COL_W-1:0]       h1_col;
   logic [COL_W-1:0]       hone_idx;
   logic                   rsp_load;
   logic                   sig_start;
   mfi_issue_type          issue;

   logic                   bias_we;
   logic [BIAS_AW-1:0]     bias_waddr;
   logic [BIAS_W-1:0]      bias_wdata;
   logic                   hone_we;
   logic                   htwo_we;

   logic [WGT_W-1:0]       weight_rdata;
   logic [BIAS_W-1:0]      bias_rdata;
   logic [FEAT_W-1:0]      feat_rdata;
   logic [ACT_W-1:0]       hone_rdata;
   logic [ACT_W-1:0]       htwo_rdata;
   logic                   mac_done;
   logic [SUM_W-1:0]       mac_sum;
   logic [ACT_W-1:0]       mac_act;
   logic                   sig_done;
   logic [PROB_W-1:0]      sig_prob;

   logic [31:0]            wd32;

   // ------------------------------------------------------------------
   // request decode
   // ------------------------------------------------------------------
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid & req_ready;
   assign op          = op_type'(req_operation);
   assign feat_we     = req_fire && (op == OP_FEATURE) && (pos_ff < nin_ff);
   assign wgt_we      = req_fire && (op == OP_WRITE_WEIGHT)
                        && (32'(req_address) < 32'(WEIGHT_WORDS));
   assign bias_req_we = req_fire && (op == OP_WRITE_BIAS)
                        && (32'(req_address) < 32'(BIAS_WORDS));

   // ------------------------------------------------------------------
   // configuration, stored already clamped
   // ------------------------------------------------------------------
   assign wd32 = 32'(csr_wdata);

   always_comb begin
      nl_in  = nl_ff;
      nin_in = nin_ff;
      h1_in  = h1_ff;
      h2_in  = h2_ff;
      dup_in = dup_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LAYER_COUNT: begin
               priority if (csr_wdata[2:0] < 3'd2) nl_in = 3'd2;
               else if (csr_wdata[2:0] > 3'd4) nl_in = 3'd4;
               else nl_in = csr_wdata[2:0];
            end
            CSR_INPUT_WIDTH: begin
               priority if (wd32 == 32'd0) nin_in = IN_CNT_W'(1);
               else if (wd32 > 32'(MAX_INPUTS)) nin_in = IN_CNT_W'(MAX_INPUTS);
               else nin_in = IN_CNT_W'(wd32);
            end
            CSR_HIDDEN_ONE: begin
               priority if (wd32[8:0] == 9'd0) h1_in = HID_CNT_W'(1);
               else if (32'(wd32[8:0]) > 32'(MAX_HIDDEN)) h1_in = HID_CNT_W'(MAX_HIDDEN);
               else h1_in = HID_CNT_W'(wd32[8:0]);
            end
            CSR_HIDDEN_TWO: begin
               priority if (wd32[8:0] == 9'd0) h2_in = HID_CNT_W'(1);
               else if (32'(wd32[8:0]) > 32'(MAX_HIDDEN)) h2_in = HID_CNT_W'(MAX_HIDDEN);
               else h2_in = HID_CNT_W'(wd32[8:0]);
            end
            CSR_DUPLICATE: dup_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // layer geometry
   // ------------------------------------------------------------------
   always_comb begin
      h1_col = COL_W'(h1_ff);
      is_out = (lyr_ff == 2'(nl_ff - 3'd2));
      priority if (lyr_ff == 2'd0) begin
         cols = COL_W'(nin_ff);
      end else if (lyr_ff == 2'd1) begin
         cols = dup_ff ? (h1_col << 1) : h1_col;
      end else begin
         cols = COL_W'(h2_ff);
      end
      priority if (is_out) begin
         rows = HID_CNT_W'(1);
      end else if (lyr_ff == 2'd0) begin
         rows = h1_ff;
      end else begin
         rows = h2_ff;
      end
      // the duplicated half reads back the first half
      hone_idx = (col_ff >= h1_col) ? (col_ff - h1_col) : col_ff;
   end

   always_comb begin
      issue.valid = (state_ff == ST_MAC);
      issue.first = (col_ff == '0);
      issue.last  = (col_ff == cols - COL_W'(1));
      issue.kind  = src_kind_type'(lyr_ff);
      issue.wzero = (waddr_ff >= WCNT_W'(WEIGHT_WORDS));
      issue.bzero = (baddr_ff >= BCNT_W'(BIAS_WORDS));
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   assign sig_start = (state_ff == ST_DRAIN) && mac_done && is_out;
   assign rsp_load  = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      lyr_in       = lyr_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      waddr_in     = waddr_ff;
      baddr_in     = baddr_ff;
      clr_in       = clr_ff;
      sum_in       = sum_ff;
      rsp_valid_in = (rsp_valid_ff & ~rsp_ready) | rsp_load;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + BIAS_AW'(1);
            if (clr_ff == BIAS_AW'(BIAS_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (op == OP_FEATURE)) begin
               if (feat_we) begin
                  pos_in = pos_ff + IN_CNT_W'(1);
               end
               if (req_last_feature) begin
                  pos_in   = '0;
                  lyr_in   = '0;
                  row_in   = '0;
                  col_in   = '0;
                  waddr_in = '0;
                  baddr_in = '0;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            waddr_in = waddr_ff + WCNT_W'(1);
            col_in   = col_ff + COL_W'(1);
            if (issue.last) begin
               col_in   = '0;
               baddr_in = baddr_ff + BCNT_W'(1);
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // hold until the neuron's sum leaves the pipeline
            if (mac_done) begin
               priority if (is_out) begin
                  sum_in   = mac_sum;
                  state_in = ST_SIG;
               end else if (row_ff == rows - HID_CNT_W'(1)) begin
                  lyr_in   = lyr_ff + 2'd1;
                  row_in   = '0;
                  state_in = ST_MAC;
               end else begin
                  row_in   = row_ff + HID_CNT_W'(1);
                  state_in = ST_MAC;
               end
            end
         end
         ST_SIG: begin
            if (sig_done) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         nl_ff        <= 3'd4;
         nin_ff       <= IN_CNT_W'(NIN_RST);
         h1_ff        <= HID_CNT_W'(H1_RST);
         h2_ff        <= HID_CNT_W'(H2_RST);
         dup_ff       <= 1'b0;
         pos_ff       <= '0;
         lyr_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         waddr_ff     <= '0;
         baddr_ff     <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nl_ff        <= nl_in;
         nin_ff       <= nin_in;
         h1_ff        <= h1_in;
         h2_ff        <= h2_in;
         dup_ff       <= dup_in;
         pos_ff       <= pos_in;
         lyr_ff       <= lyr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         waddr_ff     <= waddr_in;
         baddr_ff     <= baddr_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff <= sum_in;
      if (rsp_load) begin
         rsp_prob_ff <= sig_prob;
         rsp_raw_ff  <= sum_ff;
      end
   end

   // ------------------------------------------------------------------
   // stores
   // ------------------------------------------------------------------
   assign bias_we    = (state_ff == ST_CLEAR) || bias_req_we;
   assign bias_waddr = (state_ff == ST_CLEAR) ? clr_ff : BIAS_AW'(req_address);
   assign bias_wdata = (state_ff == ST_CLEAR) ? '0 : req_bias_value;
   assign hone_we    = (state_ff == ST_DRAIN) && mac_done && !is_out && (lyr_ff == 2'd0);
   assign htwo_we    = (state_ff == ST_DRAIN) && mac_done && !is_out && (lyr_ff == 2'd1);

   mfi_ram #(.WIDTH(WGT_W), .DEPTH(WEIGHT_WORDS)) u_weight_ram (
      .clock (clock),
      .we    (wgt_we),
      .waddr (WADDR_W'(req_address)),
      .wdata (req_weight_value),
      .raddr (waddr_ff[WADDR_W-1:0]),
      .rdata (weight_rdata)
   );

   mfi_ram #(.WIDTH(BIAS_W), .DEPTH(BIAS_WORDS)) u_bias_ram (
      .clock (clock),
      .we    (bias_we),
      .waddr (bias_waddr),
      .wdata (bias_wdata),
      .raddr (baddr_ff[BIAS_AW-1:0]),
      .rdata (bias_rdata)
   );

   mfi_ram #(.WIDTH(FEAT_W), .DEPTH(MAX_INPUTS)) u_feature_ram (
      .clock (clock),
      .we    (feat_we),
      .waddr (pos_ff[FEAT_AW-1:0]),
      .wdata (req_feature_value),
      .raddr (col_ff[FEAT_AW-1:0]),
      .rdata (feat_rdata)
   );

   mfi_ram #(.WIDTH(ACT_W), .DEPTH(MAX_HIDDEN)) u_hidden_one_ram (
      .clock (clock),
      .we    (hone_we),
      .waddr (row_ff[HID_AW-1:0]),
      .wdata (mac_act),
      .raddr (hone_idx[HID_AW-1:0]),
      .rdata (hone_rdata)
   );

   mfi_ram #(.WIDTH(ACT_W), .DEPTH(MAX_HIDDEN)) u_hidden_two_ram (
      .clock (clock),
      .we    (htwo_we),
      .waddr (row_ff[HID_AW-1:0]),
      .wdata (mac_act),
      .raddr (col_ff[HID_AW-1:0]),
      .rdata (htwo_rdata)
   );

   // ------------------------------------------------------------------
   // datapath
   // ------------------------------------------------------------------
   mfi_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .issue        (issue),
      .weight_rdata (weight_rdata),
      .bias_rdata   (bias_rdata),
      .feat_rdata   (feat_rdata),
      .hone_rdata   (hone_rdata),
      .htwo_rdata   (htwo_rdata),
      .done         (mac_done),
      .sum          (mac_sum),
      .act          (mac_act)
   );

   mfi_sigmoid u_sigmoid (
      .clock (clock),
      .reset (reset),
      .start (sig_start),
      .sum   (mac_sum),
      .done  (sig_done),
      .prob  (sig_prob)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_probability = rsp_prob_ff;
   assign rsp_raw_sum     = rsp_raw_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `MFI_ASSERT_IMPL(a_mac_done_in_drain, mac_done, state_ff == ST_DRAIN)
   `MFI_ASSERT_IMPL(a_sig_done_in_sig, sig_done, state_ff == ST_SIG)
   `MFI_ASSERT_NEXT(a_out_sum_starts_sig, sig_start, (state_ff == ST_SIG) && !sig_done)

endmodule
